@@ design/skct_pkg.sv @@
// Shared types, codes and constants for the sorted key count table.
package skct_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [31:0] add_count;
    logic [5:0]  rank;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] entry_count;
    logic [6:0]  position;
    logic [63:0] entry_key;
    logic [6:0]  occupancy;
    logic [1:0]  status;
  } out_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic        cmp;
    logic        key_op;
    logic        ins;
    logic        upd;
    logic [63:0] key;
    logic [31:0] count;
    logic [5:0]  rank;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SEL  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

endpackage

@@ design/skct_cell.sv @@
// One slot of the sorted row: holds a key and its count, compares and shifts.
module skct_cell #(
  parameter int CAPACITY = skct_pkg::CAPACITY_DEF,
  parameter int IDX      = 0
) (
  input  logic                           clk,
  input  skct_pkg::cell_ctl_t            ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]  used,
  input  logic [63:0]                    prev_key,
  input  logic [31:0]                    prev_cnt,
  input  logic                           prev_t,
  output logic [63:0]                    key_o,
  output logic [31:0]                    cnt_o,
  output logic                           t_o,
  output logic                           eq_o,
  output logic                           sel_o
);
  import skct_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int CW = (IW > 6) ? IW : 6;

  logic [63:0] key_r, key_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        t_r, t_nxt;
  logic        eq_r, eq_nxt;
  logic        valid;
  logic        sel;

  assign valid = CW'(IDX) < CW'(used);
  assign sel   = t_r & ~prev_t;

  // The flags form a thermometer along the row; the cell where it turns
  // on is the addressed rank (or the insertion point).
  always_comb begin
    if (ctl.key_op) begin
      t_nxt  = ~valid | (key_r >= ctl.key);
      eq_nxt = valid & (key_r == ctl.key);
    end else begin
      t_nxt  = CW'(IDX) >= CW'(ctl.rank);
      eq_nxt = valid;
    end
  end

  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      if (sel) begin
        key_nxt = ctl.key;
        cnt_nxt = ctl.count;
      end else if (prev_t) begin
        key_nxt = prev_key;
        cnt_nxt = prev_cnt;
      end
    end else if (ctl.upd && sel) begin
      cnt_nxt = ctl.count;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
    if (ctl.cmp) begin
      t_r  <= t_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign key_o = key_r;
  assign cnt_o = cnt_r;
  assign t_o   = t_r;
  assign eq_o  = eq_r;
  assign sel_o = sel;

endmodule

@@ design/sorted_key_count_table.sv @@
// Top level of the sorted key count table: controller and the row of cells.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   skct_pkg::in_t
//   out_     output     out_valid/out_stall skct_pkg::out_t
//
// Each item passes through S_CMP, which compares its key against every
// cell in parallel, S_SEL, which picks the addressed cell, and S_UPD, which
// writes the row and loads the result register once it is free or being emptied.
// A new item is taken in the same cycle that the previous one writes its
// result, as long as the result register is free or being emptied.
// Reset only clears the slot count and control; slot contents need none.
module sorted_key_count_table #(
  parameter int CAPACITY = skct_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  skct_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output skct_pkg::out_t  out_data
);
  import skct_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);

  state_t      state_r, state_nxt;
  in_t         item_r;
  logic [IW-1:0] used_r, used_nxt;
  logic        out_valid_r;
  out_t        out_data_r, res;

  logic        acc, out_free, full, key_op;
  cell_ctl_t   ctl;

  logic [63:0] key_a [CAPACITY];
  logic [31:0] cnt_a [CAPACITY];
  logic [CAPACITY-1:0] t_v, eq_v, sel_v;

  logic [63:0]   red_key;
  logic [31:0]   red_cnt;
  logic [IW-1:0] red_rank;
  logic          any_sel, hit;

  logic          hit_r;
  logic [63:0]   sel_key_r;
  logic [31:0]   sel_cnt_r;
  logic [IW-1:0] rank_r;
  logic [32:0]   sum;
  logic [31:0]   sum_sat;

  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = ~((state_r == S_IDLE) || ((state_r == S_UPD) && out_free));
  assign acc      = in_valid & ~in_stall;
  assign full     = used_r == IW'(CAPACITY);
  assign key_op   = (item_r.opcode == OP_ADD) || (item_r.opcode == OP_LOOKUP);

  assign sum     = {1'b0, sel_cnt_r} + {1'b0, item_r.add_count};
  assign sum_sat = sum[32] ? COUNT_MAX : sum[31:0];

  always_comb begin
    ctl        = '0;
    ctl.cmp    = state_r == S_CMP;
    ctl.key_op = key_op;
    ctl.key    = item_r.key;
    ctl.rank   = item_r.rank;
    ctl.ins    = (state_r == S_UPD) && out_free && (item_r.opcode == OP_ADD)
                 && !hit_r && !full;
    ctl.upd    = (state_r == S_UPD) && out_free && (item_r.opcode == OP_ADD)
                 && hit_r;
    ctl.count  = ctl.ins ? item_r.add_count : sum_sat;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [63:0] pk;
    logic [31:0] pc;
    logic        pt;
    if (i == 0) begin : g_head
      assign pk = '0;
      assign pc = '0;
      assign pt = 1'b0;
    end else begin : g_link
      assign pk = key_a[i-1];
      assign pc = cnt_a[i-1];
      assign pt = t_v[i-1];
    end
    skct_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .used    (used_r),
      .prev_key(pk),
      .prev_cnt(pc),
      .prev_t  (pt),
      .key_o   (key_a[i]),
      .cnt_o   (cnt_a[i]),
      .t_o     (t_v[i]),
      .eq_o    (eq_v[i]),
      .sel_o   (sel_v[i])
    );
  end

  // At most one cell is selected, so an OR across the row acts as a mux.
  always_comb begin
    red_key  = '0;
    red_cnt  = '0;
    red_rank = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_v[i]) begin
        red_key  = red_key | key_a[i];
        red_cnt  = red_cnt | cnt_a[i];
        red_rank = red_rank | IW'(i);
      end
    end
    any_sel = |sel_v;
    hit     = |(sel_v & eq_v);
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_data;
    end
    if (state_r == S_SEL) begin
      hit_r     <= hit;
      sel_key_r <= red_key;
      sel_cnt_r <= red_cnt;
      rank_r    <= any_sel ? red_rank : IW'(CAPACITY);
    end
  end

  always_comb begin
    res      = '0;
    used_nxt = used_r;
    unique case (item_r.opcode)
      OP_ADD: begin
        res.position  = 7'(rank_r);
        res.entry_key = item_r.key;
        if (hit_r) begin
          res.found       = 1'b1;
          res.entry_count = sum_sat;
          res.status      = sum[32] ? ST_SAT : ST_OK;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          res.entry_count = item_r.add_count;
          used_nxt        = used_r + 1'b1;
        end
      end
      OP_LOOKUP: begin
        res.found       = hit_r;
        res.entry_count = hit_r ? sel_cnt_r : '0;
        res.position    = 7'(rank_r);
        res.entry_key   = item_r.key;
      end
      OP_READ: begin
        res.found       = hit_r;
        res.entry_count = hit_r ? sel_cnt_r : '0;
        res.position    = 7'(item_r.rank);
        res.entry_key   = hit_r ? sel_key_r : '0;
      end
      default: begin
        res = '0;
      end
    endcase
    res.occupancy = 7'(used_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_SEL;
      S_SEL:  state_nxt = S_UPD;
      S_UPD: begin
        if (out_free) begin
          state_nxt = acc ? S_CMP : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_UPD) && out_free) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_UPD) && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= IW'(CAPACITY))
    else $error("slot count exceeds capacity");

  a_single_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL || state_r == S_UPD) |-> $onehot0(sel_v))
    else $error("more than one cell selected");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> used_r == IW'($past(used_r) + 1'b1))
    else $error("insert did not grow the table");

  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> !out_data.found)
    else $error("dropped add reported a found entry");

endmodule

@@ tb/tb_sorted_key_count_table.sv @@
// Self-checking testbench for the sorted key count table, with random stimulus and flow control.
`timescale 1ns / 100ps

module tb_sorted_key_count_table;
  import skct_pkg::*;

  localparam int TBL_DEPTH = CAPACITY_DEF;
  localparam int RANDOM_PER_PHASE = 282;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Flow-control modes, one per random phase.
  localparam int MODE_FREE = 0;
  localparam int MODE_SENDER_IDLE = 1;
  localparam int MODE_RECEIVER_STALL = 2;
  localparam int MODE_BOTH = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  sorted_key_count_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table, kept in ascending key order.
  logic [63:0] shadow_key [TBL_DEPTH];
  logic [31:0] shadow_count [TBL_DEPTH];
  int shadow_used = 0;

  in_t pending_items [$];
  out_t expected_results [$];
  logic [63:0] issued_keys [$];

  int idle_mode = MODE_FREE;
  int sender_burst = 0;
  int receiver_burst = 0;
  int cycles = 0;
  int items_queued = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int unexpected = 0;
  int n_inserts = 0;
  int n_full_drops = 0;
  int n_saturated = 0;
  int n_found = 0;
  int peak_used = 0;

  function automatic out_t predict_table(in_t it);
    out_t r;
    int rk;
    int i;
    logic [32:0] sum;
    r = '0;
    case (it.opcode)
      OP_ADD, OP_LOOKUP: begin
        rk = 0;
        while (rk < shadow_used && shadow_key[rk] < it.key) rk++;
        r.entry_key = it.key;
        r.position = 7'(rk);
        if (rk < shadow_used && shadow_key[rk] == it.key) begin
          r.found = 1'b1;
          n_found++;
          if (it.opcode == OP_ADD) begin
            sum = {1'b0, shadow_count[rk]} + {1'b0, it.add_count};
            if (sum[32]) begin
              sum = {1'b0, COUNT_MAX};
              r.status = ST_SAT;
              n_saturated++;
            end
            shadow_count[rk] = sum[31:0];
          end
          r.entry_count = shadow_count[rk];
        end else if (it.opcode == OP_ADD) begin
          if (shadow_used >= TBL_DEPTH) begin
            r.status = ST_FULL;
            n_full_drops++;
          end else begin
            for (i = shadow_used; i > rk; i--) begin
              shadow_key[i] = shadow_key[i - 1];
              shadow_count[i] = shadow_count[i - 1];
            end
            shadow_key[rk] = it.key;
            shadow_count[rk] = it.add_count;
            shadow_used++;
            n_inserts++;
            if (shadow_used > peak_used) peak_used = shadow_used;
            r.entry_count = it.add_count;
          end
        end
      end
      OP_READ: begin
        r.position = {1'b0, it.rank};
        if (int'(it.rank) < shadow_used) begin
          r.found = 1'b1;
          r.entry_count = shadow_count[it.rank];
          r.entry_key = shadow_key[it.rank];
        end
      end
      default: ;
    endcase
    r.occupancy = 7'(shadow_used);
    return r;
  endfunction

  function automatic void queue_item(logic [1:0] op, logic [63:0] k, logic [31:0] c,
                                     logic [5:0] rk);
    in_t it;
    it.opcode = op;
    it.key = k;
    it.add_count = c;
    it.rank = rk;
    pending_items.push_back(it);
    items_queued++;
    if (op == OP_ADD) issued_keys.push_back(k);
  endfunction

  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 || issued_keys.size() == 0) begin
      k = {$urandom, $urandom};
    end else if (sel < 8) begin
      // Neighbors of a known key stress the ordering compare.
      k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
      k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
    end else if (sel == 8) begin
      k = 64'($urandom_range(0, 255));
    end else begin
      k = ~64'($urandom_range(0, 255));
    end
    return k;
  endfunction

  function automatic in_t gen_item();
    in_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.opcode = sel < 42 ? OP_ADD : sel < 68 ? OP_LOOKUP : sel < 95 ? OP_READ : OP_UNUSED;
    if (issued_keys.size() < 4 || $urandom_range(0, 99) < 25) begin
      it.key = fresh_key();
    end else begin
      it.key = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    end
    sel = $urandom_range(0, 9);
    if (sel < 6) it.add_count = $urandom_range(0, 1000);
    else if (sel < 8) it.add_count = $urandom;
    else it.add_count = COUNT_MAX - $urandom_range(0, 1000);
    it.rank = $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
    if (it.opcode == OP_ADD) issued_keys.push_back(it.key);
    return it;
  endfunction

  function automatic bit sender_idles();
    int pct;
    pct = idle_mode == MODE_SENDER_IDLE ? 71 : idle_mode == MODE_BOTH ? 16 : 0;
    if (sender_burst > 0) begin
      sender_burst--;
      return 1'b0;
    end
    if ($urandom_range(0, 99) < 3) sender_burst = $urandom_range(10, 40);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit receiver_stalls();
    int pct;
    pct = idle_mode == MODE_RECEIVER_STALL ? 71 : idle_mode == MODE_BOTH ? 16 : 0;
    if (receiver_burst > 0) begin
      receiver_burst--;
      return 1'b0;
    end
    if ($urandom_range(0, 99) < 3) receiver_burst = $urandom_range(10, 40);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void note_mismatch(string fld, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("result %0d: %s expected %h, got %h", results_checked, fld, exp_v, got_v);
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      unexpected++;
      $display("result beat with nothing outstanding: %h", got);
      return;
    end
    want = expected_results.pop_front();
    if (got.found !== want.found) begin
      note_mismatch("found", 64'(want.found), 64'(got.found));
    end
    if (got.entry_count !== want.entry_count) begin
      note_mismatch("entry_count", 64'(want.entry_count), 64'(got.entry_count));
    end
    if (got.position !== want.position) begin
      note_mismatch("position", 64'(want.position), 64'(got.position));
    end
    if (got.entry_key !== want.entry_key) begin
      note_mismatch("entry_key", want.entry_key, got.entry_key);
    end
    if (got.occupancy !== want.occupancy) begin
      note_mismatch("occupancy", 64'(want.occupancy), 64'(got.occupancy));
    end
    if (got.status !== want.status) begin
      note_mismatch("status", 64'(want.status), 64'(got.status));
    end
    results_checked++;
  endfunction

  // Driver: predicts each accepted beat, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_table(in_data));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && !sender_idles()) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat and applies back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= receiver_stalls();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out with %0d results outstanding", expected_results.size());
      $display("sorted_key_count_table regression: fail");
      $finish;
    end
  end

  task automatic wait_drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0 ||
           results_checked < items_queued) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int ph;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty table, extreme keys and counts, saturation,
    // misses on both sides of stored keys, reads past occupancy, unused opcode.
    queue_item(OP_READ, 64'd0, 32'd0, 6'd0);
    queue_item(OP_LOOKUP, 64'd0, 32'd0, 6'd0);
    queue_item(OP_ADD, '1, 32'd5, 6'h3F);
    queue_item(OP_ADD, 64'd0, 32'd0, 6'd0);
    queue_item(OP_ADD, 64'h8000_0000_0000_0000, COUNT_MAX, 6'd0);
    queue_item(OP_ADD, 64'h8000_0000_0000_0000, 32'd1, 6'd0);
    queue_item(OP_ADD, 64'h8000_0000_0000_0000, 32'd0, 6'd0);
    queue_item(OP_ADD, '1, 32'hFFFF_FFFA, 6'd0);
    queue_item(OP_ADD, '1, 32'd1, 6'd0);
    queue_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 32'd0, 6'd0);
    queue_item(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, COUNT_MAX, 6'h3F);
    queue_item(OP_LOOKUP, '1, 32'd0, 6'd0);
    queue_item(OP_ADD, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 6'h2A);
    queue_item(OP_ADD, 64'd1, 32'd7, 6'h15);
    queue_item(OP_READ, 64'd0, 32'd0, 6'd0);
    queue_item(OP_READ, 64'd0, 32'd0, 6'd1);
    queue_item(OP_READ, 64'd0, 32'd0, 6'd2);
    queue_item(OP_READ, 64'd0, 32'd0, 6'd3);
    queue_item(OP_READ, 64'd0, 32'd0, 6'd4);
    queue_item(OP_READ, '1, COUNT_MAX, 6'd5);
    queue_item(OP_READ, 64'd0, 32'd0, 6'h3F);
    queue_item(OP_UNUSED, '1, COUNT_MAX, 6'h3F);
    queue_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 6'd0);
    wait_drain();

    // Each phase ends with the sender held back until every result is in.
    for (ph = MODE_FREE; ph <= MODE_BOTH; ph++) begin
      idle_mode = ph;
      repeat (RANDOM_PER_PHASE) pending_items.push_back(gen_item());
      items_queued += RANDOM_PER_PHASE;
      wait_drain();
    end
    idle_mode = MODE_FREE;
    repeat (12) @(posedge clk);

    $display("%0d beats sent under four flow-control modes, %0d results checked, %0d hits",
             items_sent, results_checked, n_found);
    $display("%0d keys inserted (peak %0d), %0d adds dropped when full, %0d sums saturated",
             n_inserts, peak_used, n_full_drops, n_saturated);
    if (mismatches == 0 && unexpected == 0) begin
      $display("sorted_key_count_table regression: pass");
    end else begin
      $display("%0d field mismatches, %0d unexpected results", mismatches, unexpected);
      $display("sorted_key_count_table regression: fail");
    end
    $finish;
  end

endmodule
